// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers shared by the timer table RTL. They expect clk and
// rst_n in scope and compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DTT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define DTT_ASSERT(lbl, prop, msg)
`define DTT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== design/dtt_pkg.sv =====
// ----------------------------------------------------------------------------
// dtt_pkg
// Types and constants shared by the deadline timer table modules.
// ----------------------------------------------------------------------------
package dtt_pkg;

  // Default table size.
  localparam int SLOTS_DEF = 16;

  // Most fired results that one check reports.
  localparam int MAX_RESULTS = 16;
  localparam int KW          = $clog2(MAX_RESULTS + 1);

  // Field widths of the request and result words.
  localparam int TIME_W    = 32;
  localparam int DELAY_W   = 24;
  localparam int HANDLE_W  = 4;
  localparam int SLOT_ID_W = 4;
  localparam int DL_W      = 33;

  // Request codes.
  typedef logic [1:0] req_t;
  localparam req_t REQ_ADD   = 2'd0;
  localparam req_t REQ_DEL   = 2'd1;
  localparam req_t REQ_CHECK = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_SLOT,
    ST_EVAL,
    ST_RESP
  } state_t;

  // Slot store controls: fill writes deadline and repeat mark and sets the
  // valid bit, clr drops the valid bit of another slot.
  typedef struct packed {
    logic fill;
    logic clr;
  } slot_ctl_t;

endpackage

// ===== design/deadline_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_table_core
// Table of one-shot and repeating deadline timers with add, delete and check
// requests, run by a small sequencer over a slot store and an age list RAM.
// ----------------------------------------------------------------------------
// Sequencing: an add scans upward from slot 0 to the lowest free slot, or to
//   the last slot when the table is full; a live delete or a check walks the L
//   live entries newest first, with one list read and one compare for each.
// A free handle or an empty check goes straight to the final word; the unused code is dropped.
// Handshake: the final word shows in the first idle cycle and the next request
//   may start then; the receiver cannot stall. Reset clears valid bits and count.
`include "assert_macros.svh"

module deadline_timer_table_core #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_req_type,
  input  logic [dtt_pkg::TIME_W-1:0]    in_now_time,
  input  logic [dtt_pkg::DELAY_W-1:0]   in_delay,
  input  logic                          in_repeat_req,
  input  logic [dtt_pkg::HANDLE_W-1:0]  in_handle,
  output logic                          out_valid,
  output logic [dtt_pkg::SLOT_ID_W-1:0] out_slot_id,
  output logic                          out_fired,
  output logic                          out_ok,
  output logic                          out_last
);
  import dtt_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int PW = SW + 2;
  localparam logic [SW-1:0] LAST_POS = SW'(SLOTS - 1);

  // Circular list position helpers.
  function automatic logic [SW-1:0] pos_dec(input logic [SW-1:0] p);
    return (p == '0) ? LAST_POS : p - 1'b1;
  endfunction

  function automatic logic [SW-1:0] pos_inc(input logic [SW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [SW-1:0] pos_add(input logic [SW-1:0] a,
                                            input logic [CW-1:0] b);
    logic [PW-1:0] sum;
    sum = PW'(a) + PW'(b);
    if (sum >= PW'(SLOTS)) begin
      sum = sum - PW'(SLOTS);
    end
    return sum[SW-1:0];
  endfunction

  // Sequencer and walk state.
  state_t state_r, state_nxt;
  req_t                 req_r;
  logic [TIME_W-1:0]    now_r;
  logic [DELAY_W-1:0]   delay_r;
  logic                 rep_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [SW-1:0]        head_r, head_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [SW-1:0]        rd_pos_r, rd_pos_nxt;
  logic [SW-1:0]        wr_pos_r, wr_pos_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic                 pend_vld_r, pend_vld_nxt;
  logic [SW-1:0]        pend_slot_r, pend_slot_nxt;
  logic [SW-1:0]        scan_r, scan_nxt;
  logic                 res_ok_r, res_ok_nxt;
  logic [SLOT_ID_W-1:0] res_slot_r, res_slot_nxt;

  // Output word registers.
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_ID_W-1:0] out_slot_r, out_slot_nxt;
  logic                 out_fired_r, out_fired_nxt;
  logic                 out_ok_r, out_ok_nxt;
  logic                 out_last_r, out_last_nxt;

  // Submodule connections.
  slot_ctl_t        slot_ctl;
  logic [SW-1:0]    slot_wr_idx;
  logic [SW-1:0]    slot_clr_idx;
  logic [DL_W:0]    slot_wr_data;
  logic [DL_W:0]    slot_rd_data;
  logic [SLOTS-1:0] slot_valid;
  logic             age_we;
  logic [SW-1:0]    age_waddr;
  logic [SW-1:0]    age_wdata;
  logic [SW-1:0]    age_rdata;

  logic             accept;
  logic             del_found;
  logic [SW-1:0]    walk_top;
  logic [SW-1:0]    list_tail;
  logic [DL_W-1:0]  cur_deadline;
  logic             cur_repeat;
  logic             fire;
  logic             keep;

  dtt_slot_store #(
    .SLOTS   (SLOTS)
  ) u_slot_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (slot_ctl),
    .wr_idx  (slot_wr_idx),
    .wr_data (slot_wr_data),
    .clr_idx (slot_clr_idx),
    .rd_idx  (age_rdata),
    .rd_data (slot_rd_data),
    .valid   (slot_valid)
  );

  dtt_age_ram #(
    .DEPTH (SLOTS),
    .WIDTH (SW)
  ) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (age_waddr),
    .wdata (age_wdata),
    .raddr (rd_pos_r),
    .rdata (age_rdata)
  );

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // A delete finds its handle only when it names a live slot of the table.
  always_comb begin
    del_found = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < (1 << HANDLE_W) && in_handle == HANDLE_W'(i)) begin
        del_found = slot_valid[i];
      end
    end
  end

  // Newest and next free positions of the age list.
  assign walk_top  = pos_add(head_r, cnt_r - 1'b1);
  assign list_tail = pos_add(head_r, cnt_r);

  // Shared compare unit: the entry read last is due when its deadline is
  // not later than now, while the result cap is not reached.
  assign cur_deadline = slot_rd_data[DL_W-1:0];
  assign cur_repeat   = slot_rd_data[DL_W];
  assign fire = (req_r == REQ_CHECK) && (k_r < KW'(MAX_RESULTS)) &&
                ({1'b0, now_r} >= cur_deadline);
  assign keep = (req_r == REQ_DEL) ? (age_rdata != SW'(handle_r))
                                   : (!fire || cur_repeat);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_req_type)
            REQ_ADD:   state_nxt = ST_SCAN;
            REQ_DEL:   state_nxt = del_found ? ST_AGE : ST_RESP;
            REQ_CHECK: state_nxt = (cnt_r == '0) ? ST_RESP : ST_AGE;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (!slot_valid[scan_r] || scan_r == LAST_POS) begin
          state_nxt = ST_RESP;
        end
      end
      ST_AGE:  state_nxt = ST_SLOT;
      ST_SLOT: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = (rem_r == '0) ? ST_RESP : ST_SLOT;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs of each state.
  always_comb begin
    logic [SW-1:0] wr_pos_w;
    logic [CW-1:0] n_w;

    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    rd_pos_nxt    = rd_pos_r;
    wr_pos_nxt    = wr_pos_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    pend_vld_nxt  = pend_vld_r;
    pend_slot_nxt = pend_slot_r;
    scan_nxt      = scan_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_fired_nxt = out_fired_r;
    out_ok_nxt    = out_ok_r;
    out_last_nxt  = out_last_r;
    slot_ctl      = '0;
    slot_wr_idx   = scan_r;
    slot_wr_data  = {rep_r, {1'b0, now_r} + DL_W'(delay_r)};
    slot_clr_idx  = age_rdata;
    age_we        = 1'b0;
    age_waddr     = wr_pos_r;
    age_wdata     = age_rdata;
    wr_pos_w      = wr_pos_r;
    n_w           = n_r;

    unique case (state_r)
      ST_IDLE: begin
        // Prepare a newest-first walk and free a deleted slot at once.
        if (accept) begin
          k_nxt        = '0;
          pend_vld_nxt = 1'b0;
          scan_nxt     = '0;
          rd_pos_nxt   = walk_top;
          wr_pos_nxt   = walk_top;
          rem_nxt      = cnt_r;
          n_nxt        = '0;
          if (in_req_type == REQ_DEL) begin
            res_ok_nxt = del_found;
            if (del_found) begin
              slot_ctl.clr = 1'b1;
              slot_clr_idx = SW'(in_handle);
            end
          end
        end
      end
      ST_SCAN: begin
        // Lowest free slot search, one slot a cycle.
        if (!slot_valid[scan_r]) begin
          slot_ctl.fill = 1'b1;
          age_we        = 1'b1;
          age_waddr     = list_tail;
          age_wdata     = scan_r;
          cnt_nxt       = cnt_r + 1'b1;
          res_ok_nxt    = 1'b1;
          res_slot_nxt  = SLOT_ID_W'(scan_r);
        end else if (scan_r == LAST_POS) begin
          res_ok_nxt    = 1'b0;
          res_slot_nxt  = '0;
        end else begin
          scan_nxt      = scan_r + 1'b1;
        end
      end
      ST_AGE: begin
        // The first list read is under way.
      end
      ST_SLOT: begin
        // The slot read is under way; move the list read on.
        rd_pos_nxt = pos_dec(rd_pos_r);
        rem_nxt    = rem_r - 1'b1;
      end
      ST_EVAL: begin
        // A fired entry is held back one step so that the final one can
        // carry the last flag.
        if (fire) begin
          k_nxt         = k_r + 1'b1;
          pend_vld_nxt  = 1'b1;
          pend_slot_nxt = age_rdata;
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_slot_nxt  = SLOT_ID_W'(pend_slot_r);
            out_fired_nxt = 1'b1;
            out_ok_nxt    = 1'b0;
            out_last_nxt  = 1'b0;
          end
          if (!cur_repeat) begin
            slot_ctl.clr = 1'b1;
            slot_clr_idx = age_rdata;
          end
        end
        // Survivors are packed toward the newest end, order kept.
        if (keep) begin
          age_we   = 1'b1;
          wr_pos_w = pos_dec(wr_pos_r);
          n_w      = n_r + 1'b1;
        end
        wr_pos_nxt = wr_pos_w;
        n_nxt      = n_w;
        if (rem_r == '0) begin
          cnt_nxt  = n_w;
          head_nxt = pos_inc(wr_pos_w);
        end
      end
      ST_RESP: begin
        // Final word of the request.
        out_valid_nxt = 1'b1;
        out_last_nxt  = 1'b1;
        out_fired_nxt = 1'b0;
        out_ok_nxt    = res_ok_r;
        out_slot_nxt  = res_slot_r;
        if (req_r == REQ_DEL) begin
          out_slot_nxt = handle_r;
        end else if (req_r == REQ_CHECK) begin
          out_ok_nxt    = 1'b0;
          out_fired_nxt = pend_vld_r;
          out_slot_nxt  = pend_vld_r ? SLOT_ID_W'(pend_slot_r) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r    <= in_req_type;
      now_r    <= in_now_time;
      delay_r  <= in_delay;
      rep_r    <= in_repeat_req;
      handle_r <= in_handle;
    end
    rd_pos_r    <= rd_pos_nxt;
    wr_pos_r    <= wr_pos_nxt;
    rem_r       <= rem_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    pend_vld_r  <= pend_vld_nxt;
    pend_slot_r <= pend_slot_nxt;
    scan_r      <= scan_nxt;
    res_ok_r    <= res_ok_nxt;
    res_slot_r  <= res_slot_nxt;
    out_slot_r  <= out_slot_nxt;
    out_fired_r <= out_fired_nxt;
    out_ok_r    <= out_ok_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_slot_id = out_slot_r;
  assign out_fired   = out_fired_r;
  assign out_ok      = out_ok_r;
  assign out_last    = out_last_r;

  // Checks on the table bookkeeping; the fire count is only defined while busy.
  `DTT_ASSERT(a_cnt_bound, cnt_r <= CW'(SLOTS), "live count exceeds the table size")
  `DTT_ASSERT(a_idle_count, !busy |-> ($countones(slot_valid) == int'(cnt_r)), "live count off")
  `DTT_ASSERT(a_last_idle, (out_valid && out_last) |-> !busy, "final word shown while busy")
  `DTT_ASSERT(a_walk_bound, (state_r == ST_SLOT) |-> ((n_r + rem_r) <= cnt_r), "walk overrun")
  `DTT_NEVER(a_fire_cap, busy && (k_r > KW'(MAX_RESULTS)), "check fired past the cap")

endmodule

// ===== design/dtt_age_ram.sv =====
// ----------------------------------------------------------------------------
// dtt_age_ram
// Single write, single read RAM with registered read data. Holds the live
// slot numbers as a circular list, oldest entry at the head.
// ----------------------------------------------------------------------------
module dtt_age_ram #(
  parameter int DEPTH = dtt_pkg::SLOTS_DEF,
  parameter int WIDTH = $clog2(dtt_pkg::SLOTS_DEF)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import dtt_pkg::*;

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/dtt_slot_store.sv =====
// ----------------------------------------------------------------------------
// dtt_slot_store
// Per-slot valid bits in flip-flops plus a RAM of deadline and repeat mark
// with a registered read port.
// ----------------------------------------------------------------------------
module dtt_slot_store #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dtt_pkg::slot_ctl_t       ctl,
  input  logic [$clog2(SLOTS)-1:0] wr_idx,
  input  logic [dtt_pkg::DL_W:0]   wr_data,
  input  logic [$clog2(SLOTS)-1:0] clr_idx,
  input  logic [$clog2(SLOTS)-1:0] rd_idx,
  output logic [dtt_pkg::DL_W:0]   rd_data,
  output logic [SLOTS-1:0]         valid
);
  import dtt_pkg::*;

  logic [SLOTS-1:0] valid_r;
  logic [DL_W:0]    mem_r [SLOTS];

  // Valid bits: a fill marks the slot live, a clear frees another one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ctl.fill) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (ctl.clr) begin
        valid_r[clr_idx] <= 1'b0;
      end
    end
  end

  // Deadline and repeat mark, written when a slot is filled.
  always_ff @(posedge clk) begin
    if (ctl.fill) begin
      mem_r[wr_idx] <= wr_data;
    end
  end

  // Registered read of the slot under evaluation.
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_idx];
  end

  assign valid = valid_r;

endmodule
